// File: rtl/tcw_pkg.sv
package tcw_pkg;

    // Screen geometry
    localparam int SCREEN_COLS = 80;
    localparam int OUTPUT_ROWS = 24;
    localparam int CELL_COUNT  = SCREEN_COLS * OUTPUT_ROWS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int ROW_W       = $clog2(OUTPUT_ROWS);
    localparam int COL_W       = $clog2(SCREEN_COLS);

    // Item actions
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] BLANK_CODE   = 8'd32;
    localparam logic [7:0] RESET_COLOR  = 8'h0F;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        scrolled;
    } t_out;

    typedef struct packed {
        logic capture;  // latch the incoming item
        logic exec;     // execute the latched item
        logic sweep;    // advance the store sweep by one cell
        logic init;     // sweep belongs to the reset clearing pass
        logic finish;   // report the result of a swept item
    } t_cmd;

    typedef struct packed {
        logic need_sweep;
        logic sweep_last;
    } t_status;

endpackage

// File: rtl/tcw_ctrl.sv
module tcw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  tcw_pkg::t_status i_status,
    output tcw_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_INIT       = 3'd0;
    localparam logic [2:0] S_INIT_DRAIN = 3'd1;
    localparam logic [2:0] S_IDLE       = 3'd2;
    localparam logic [2:0] S_EXEC       = 3'd3;
    localparam logic [2:0] S_SWEEP      = 3'd4;
    localparam logic [2:0] S_DRAIN      = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep = 1'b1;
                o_cmd.init  = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_INIT_DRAIN;
                end
            end
            S_INIT_DRAIN: begin
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.need_sweep ? S_SWEEP : S_IDLE;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: rtl/tcw_dp.sv
module tcw_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcw_pkg::t_cmd    i_cmd,
    output tcw_pkg::t_status o_status,
    input  tcw_pkg::t_in     i_item,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    output logic             o_strobe,
    output tcw_pkg::t_out    o_result
);

    localparam int AW = tcw_pkg::ADDR_W;
    localparam int RW = tcw_pkg::ROW_W;
    localparam int CW = tcw_pkg::COL_W;

    logic [15:0] mem [tcw_pkg::CELL_COUNT];

    logic [7:0]        r_color;
    tcw_pkg::t_in      r_item;
    logic              r_rd_ok;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic              r_copy;
    logic              r_scroll;
    logic [AW-1:0]     r_cnt;
    logic [15:0]       r_rdata;
    logic              r_wval;
    logic [AW-1:0]     r_wdst;
    logic              r_wcopy;
    logic [15:0]       r_wblank;
    logic              r_strobe;
    tcw_pkg::t_out     r_res;

    logic [RW-1:0] n_row;
    logic [CW-1:0] n_col;
    logic          is_put;
    logic          is_nl;
    logic          adv_line;
    logic          do_scroll;
    logic          need_sweep;
    logic          char_we;
    logic          in_range;
    logic          last_row;
    logic [AW-1:0] pos;
    logic [AW-1:0] rd_addr;
    logic [7:0]    sweep_attr;

    // Decode the latched item
    always_comb begin
        is_put     = (r_item.action == tcw_pkg::ACT_PUT);
        is_nl      = (r_item.char_code == tcw_pkg::NEWLINE_CODE);
        last_row   = (r_row == RW'(tcw_pkg::OUTPUT_ROWS - 1));
        adv_line   = is_put && (is_nl || (r_col == CW'(tcw_pkg::SCREEN_COLS - 1)));
        do_scroll  = adv_line && last_row;
        need_sweep = do_scroll || (r_item.action == tcw_pkg::ACT_CLEAR);
        char_we    = i_cmd.exec && is_put && !is_nl;
        pos        = AW'(r_row) * AW'(tcw_pkg::SCREEN_COLS) + AW'(r_col);

        n_row = r_row;
        n_col = r_col;
        if (r_item.action == tcw_pkg::ACT_CLEAR) begin
            n_row = '0;
            n_col = '0;
        end else if (adv_line) begin
            n_col = '0;
            if (!last_row) begin
                n_row = r_row + RW'(1);
            end
        end else if (is_put) begin
            n_col = r_col + CW'(1);
        end
    end

    assign o_status.need_sweep = need_sweep;
    assign o_status.sweep_last = (r_cnt == AW'(tcw_pkg::CELL_COUNT - 1));

    assign in_range   = (32'(i_item.cell_index) < 32'(tcw_pkg::CELL_COUNT));
    assign rd_addr    = i_cmd.sweep ? (r_cnt + AW'(tcw_pkg::SCREEN_COLS))
                      : (in_range ? AW'(i_item.cell_index) : '0);
    assign sweep_attr = i_cmd.init ? tcw_pkg::RESET_COLOR : r_color;

    // Store: one read port, one write port
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_wval) begin
            mem[r_wdst] <= r_wcopy ? r_rdata : r_wblank;
        end else if (char_we) begin
            mem[pos] <= {r_color, r_item.char_code};
        end
    end

    // Sweep: issue the read for a cell, write it in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_wval <= 1'b0;
        end else begin
            r_wval <= i_cmd.sweep;
            if (i_cmd.sweep) begin
                r_cnt <= o_status.sweep_last ? '0 : r_cnt + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wdst   <= r_cnt;
        r_wcopy  <= r_copy && (r_cnt < AW'(tcw_pkg::CELL_COUNT - tcw_pkg::SCREEN_COLS));
        r_wblank <= {sweep_attr, tcw_pkg::BLANK_CODE};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color  <= tcw_pkg::RESET_COLOR;
            r_row    <= '0;
            r_col    <= '0;
            r_copy   <= 1'b0;
            r_scroll <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_row    <= n_row;
                r_col    <= n_col;
                r_copy   <= do_scroll;
                r_scroll <= do_scroll;
            end
            r_strobe <= (i_cmd.exec && !need_sweep) || i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item  <= i_item;
            r_rd_ok <= in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !need_sweep) begin
            r_res.cell_data  <= ((r_item.action == tcw_pkg::ACT_READ) && r_rd_ok)
                                ? r_rdata : 16'd0;
            r_res.cursor_row <= 5'(n_row);
            r_res.cursor_col <= 7'(n_col);
            r_res.scrolled   <= 1'b0;
        end else if (i_cmd.finish) begin
            r_res.cell_data  <= 16'd0;
            r_res.cursor_row <= 5'(r_row);
            r_res.cursor_col <= 7'(r_col);
            r_res.scrolled   <= r_scroll;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

// File: rtl/text_console_writer_top.sv
// Text console writer: a screen store of character cells plus a write position.
//
// Item channel: present an item on i_item with start high; it is taken at the
// rising edge where busy is low. busy stays high while the item is worked on.
// Result channel: o_strobe marks the single cycle in which o_result is valid;
// the receiver must take it then, there is no stall path.
// Config: i_cfg_we with i_cfg_wdata writes the text color at that edge.
//
// Per action, on the cell store (one read, one write port) and sweep counter:
//   put character, read, unused action: executed, then strobed; busy drops in
//   that same cycle, so the next item can already be taken with the strobe.
//   clear, or a put that scrolls: the store is swept one cell per cycle
//   (copy from the row below, or blank), then the strobe follows.
// Reset: synchronous, active low. Afterwards a clearing pass blanks all
// CELL_COUNT cells with busy high; config writes are still taken during
// that pass.
module text_console_writer_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tcw_pkg::t_in  i_item,
    output logic          o_strobe,
    output tcw_pkg::t_out o_result,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata
);

    tcw_pkg::t_cmd    cmd;
    tcw_pkg::t_status status;

    // Sequence each item: capture, execute, then sweep the store if needed
    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Hold the cell store, write position, color and result register
    tcw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

// File: rtl/tcw_chk.sv
module tcw_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_strobe,
    input tcw_pkg::t_out o_result
);

    // An accepted item keeps the block busy for its execute cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after an accepted item");

    // No result in the cycle after an accept
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("result strobe in the execute cycle");

    // A result only appears once the block is free again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // A scroll always leaves the position at column 0 after a sweep
    a_scroll_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.scrolled) |-> ((o_result.cursor_col == 7'd0) && $past(busy)))
        else $error("scroll result with nonzero column");

endmodule

bind text_console_writer_top tcw_chk u_chk (.*);

// File: sim/tb_text_console_writer_top.sv
`timescale 1ns / 100ps

module tb_text_console_writer_top;
    import tcw_pkg::*;

    // The block has no name for the fourth action code; it must leave everything as is.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int IDLE_PCT        = 26;
    localparam int SETTLE_CYCLES   = 8;
    // Generous hang guard, far beyond any correct run, sweeps included.
    localparam int RUN_LIMIT_NS    = 100_000_000;

    // Shadow copy of the screen: cells, write position and color.
    // It predicts the result of each accepted item and matches results in order.
    class console_shadow;
        localparam int MAX_PRINTED = 40;

        logic [15:0] cells [CELL_COUNT];
        int          row;
        int          col;
        logic [7:0]  color;
        t_out        due_results[$];
        int          errors;
        int          scrolls;
        int          clears;
        int          reads;

        function new();
            color   = RESET_COLOR;
            row     = 0;
            col     = 0;
            errors  = 0;
            scrolls = 0;
            clears  = 0;
            reads   = 0;
            blank_all();
        endfunction

        function void blank_all();
            foreach (cells[i]) cells[i] = {color, BLANK_CODE};
        endfunction

        // Move to column 0 of the next row; scroll up at the bottom.
        function bit next_line();
            col = 0;
            row++;
            if (row >= OUTPUT_ROWS) begin
                for (int i = 0; i < CELL_COUNT - SCREEN_COLS; i++)
                    cells[i] = cells[i + SCREEN_COLS];
                for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++)
                    cells[i] = {color, BLANK_CODE};
                row = OUTPUT_ROWS - 1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function t_out next_screen_result(t_in it);
            t_out r;
            int   pos;
            r = '0;
            case (it.action)
                ACT_PUT: begin
                    if (it.char_code == NEWLINE_CODE) begin
                        r.scrolled = next_line();
                    end else begin
                        pos = row * SCREEN_COLS + col;
                        cells[pos] = {color, it.char_code};
                        col++;
                        if (col >= SCREEN_COLS) r.scrolled = next_line();
                    end
                end
                ACT_CLEAR: begin
                    blank_all();
                    row = 0;
                    col = 0;
                    clears++;
                end
                ACT_READ: begin
                    reads++;
                    if (int'(it.cell_index) < CELL_COUNT) r.cell_data = cells[it.cell_index];
                end
                default: ;
            endcase
            if (r.scrolled) scrolls++;
            r.cursor_row = row[4:0];
            r.cursor_col = col[6:0];
            return r;
        endfunction

        function void note_item(t_in it);
            due_results.push_back(next_screen_result(it));
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_out got);
            t_out want;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result %h with no item outstanding", got));
            end else begin
                want = due_results.pop_front();
                if (got.cell_data !== want.cell_data)
                    report_mismatch($sformatf("cell_data %h, want %h",
                                              got.cell_data, want.cell_data));
                if (got.cursor_row !== want.cursor_row)
                    report_mismatch($sformatf("cursor_row %0d, want %0d",
                                              got.cursor_row, want.cursor_row));
                if (got.cursor_col !== want.cursor_col)
                    report_mismatch($sformatf("cursor_col %0d, want %0d",
                                              got.cursor_col, want.cursor_col));
                if (got.scrolled !== want.scrolled)
                    report_mismatch($sformatf("scrolled %b, want %b",
                                              got.scrolled, want.scrolled));
            end
        endtask
    endclass

    // Every input starts at a known value; reset is held from time zero.
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    t_in        i_item      = '0;
    logic       o_strobe;
    t_out       o_result;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = '0;

    console_shadow shadow = new();
    t_in           directed_items[$];
    int            items_sent = 0;
    int            sender_idle_pct = IDLE_PCT;

    text_console_writer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hang guard: a correct run never gets here.
    initial begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // Results cannot be held off: take one on every strobe and match it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) shadow.check_result(o_result);
    end

    function automatic t_in make_item(logic [1:0] action, logic [7:0] ch, logic [10:0] idx);
        t_in it;
        it.action     = action;
        it.char_code  = ch;
        it.cell_index = idx;
        return it;
    endfunction

    // Present one item and hold it until the edge that takes it (start high, busy low).
    // Start stays high on return so back-to-back items need no extra assignment.
    task automatic send_item(t_in it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        shadow.note_item(it);
        items_sent++;
    endtask

    // Drop start for a random number of cycles (geometric, about 26 in 100, none in phase 2).
    task automatic sender_gap();
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain();
        start <= 1'b0;
        while (shadow.due_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0]  phase_colors [NUM_PHASES];
        int          target;
        int          pick;
        int          burst_len;
        logic [7:0]  ch;
        logic [10:0] idx;

        phase_colors[0] = RESET_COLOR;  // phase 0 runs on the color reset leaves behind
        phase_colors[1] = 8'h00;
        phase_colors[2] = 8'hFF;
        phase_colors[3] = 8'($urandom_range(255));
        phase_colors[4] = 8'($urandom_range(255));
        phase_colors[5] = RESET_COLOR;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Let the post-reset clearing pass run out before the first item.
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);

        // Directed: read extremes of the store and past its end, the unused action,
        // control bytes and byte extremes as characters, newlines, clear and read-back.
        directed_items.push_back(make_item(ACT_READ,   8'h00, 11'd0));
        directed_items.push_back(make_item(ACT_READ,   8'hFF, 11'd1919));
        directed_items.push_back(make_item(ACT_READ,   8'h5A, 11'd1920));
        directed_items.push_back(make_item(ACT_READ,   8'h00, 11'h7FF));
        directed_items.push_back(make_item(ACT_UNUSED, 8'hFF, 11'h7FF));
        directed_items.push_back(make_item(ACT_UNUSED, 8'h00, 11'd0));
        directed_items.push_back(make_item(ACT_PUT,    8'h00, 11'h7FF));
        directed_items.push_back(make_item(ACT_PUT,    8'hFF, 11'd0));
        directed_items.push_back(make_item(ACT_PUT,    8'h09, 11'h555));
        directed_items.push_back(make_item(ACT_PUT,    8'h7F, 11'h2AA));
        directed_items.push_back(make_item(ACT_PUT,    NEWLINE_CODE, 11'h7FF));
        directed_items.push_back(make_item(ACT_PUT,    NEWLINE_CODE, 11'd0));
        directed_items.push_back(make_item(ACT_PUT,    8'h41, 11'd5));
        directed_items.push_back(make_item(ACT_READ,   8'h0A, 11'd0));
        directed_items.push_back(make_item(ACT_READ,   8'h00, 11'd1));
        directed_items.push_back(make_item(ACT_READ,   8'h00, 11'd2));
        directed_items.push_back(make_item(ACT_READ,   8'h00, 11'd3));
        directed_items.push_back(make_item(ACT_READ,   8'h00, 11'd160));
        directed_items.push_back(make_item(ACT_READ,   8'h00, 11'd161));
        directed_items.push_back(make_item(ACT_CLEAR,  8'hFF, 11'h7FF));
        directed_items.push_back(make_item(ACT_READ,   8'h00, 11'd0));
        directed_items.push_back(make_item(ACT_READ,   8'h00, 11'd160));
        directed_items.push_back(make_item(ACT_PUT,    NEWLINE_CODE, 11'd0));
        directed_items.push_back(make_item(ACT_READ,   8'h00, 11'd1919));
        foreach (directed_items[i]) begin
            sender_gap();
            send_item(directed_items[i]);
        end

        // Random phases, one text color each. Mostly text with newlines and reads,
        // with runs of characters long enough to wrap; clears are rare so the
        // position reaches the bottom row and newlines and wraps keep scrolling.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                drain();
                i_cfg_we    <= 1'b1;
                i_cfg_wdata <= phase_colors[p];
                @(posedge i_clk);
                i_cfg_we    <= 1'b0;
                shadow.color = phase_colors[p];
            end
            // One whole phase runs with no random idle gaps between items.
            sender_idle_pct = (p == 2) ? 0 : IDLE_PCT;
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                pick = $urandom_range(999);
                if (pick < 30) begin
                    burst_len = $urandom_range(80, 1);
                    repeat (burst_len) begin
                        ch = 8'($urandom_range(255));
                        if (ch == NEWLINE_CODE) ch = BLANK_CODE;
                        sender_gap();
                        send_item(make_item(ACT_PUT, ch, 11'($urandom)));
                    end
                    sender_gap();
                    send_item(make_item(ACT_PUT, NEWLINE_CODE, 11'($urandom)));
                end else if (pick < 580) begin
                    ch = ($urandom_range(99) < 12) ? NEWLINE_CODE : 8'($urandom_range(255));
                    sender_gap();
                    send_item(make_item(ACT_PUT, ch, 11'($urandom)));
                end else if (pick < 920) begin
                    // Half the reads land near the write row, where the text is.
                    if ($urandom_range(1) == 1)
                        idx = 11'(shadow.row * SCREEN_COLS + $urandom_range(159));
                    else
                        idx = 11'($urandom_range(2047));
                    sender_gap();
                    send_item(make_item(ACT_READ, 8'($urandom), idx));
                end else if (pick < 997) begin
                    sender_gap();
                    send_item(make_item(ACT_UNUSED, 8'($urandom), 11'($urandom)));
                end else begin
                    sender_gap();
                    send_item(make_item(ACT_CLEAR, 8'($urandom), 11'($urandom)));
                end
                if ($urandom_range(149) == 0) drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (shadow.due_results.size() != 0) begin
            void'(shadow.due_results.pop_front());
            shadow.report_mismatch("expected result never arrived");
        end

        $display("Ran %0d items over %0d text colors: %0d reads, %0d scrolls, %0d clears.",
                 items_sent, NUM_PHASES, shadow.reads, shadow.scrolls, shadow.clears);
        $display("Mismatches counted: %0d.", shadow.errors);
        if (shadow.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
